/* hdl/rmv_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmv_pkg
// Shared constants, types and state encoding for the running mean/variance
// block.
// ----------------------------------------------------------------------------
package rmv_pkg;

  localparam int SAMPLE_WIDTH = 32;
  localparam int COUNT_WIDTH  = 32;
  localparam int M2_W         = 64;
  localparam int VAR_W        = 63;
  localparam int ROOT_W       = 32;
  localparam int DIV_W        = 64;
  localparam int DIV_CNT_W    = $clog2(DIV_W + 1);
  localparam int MUL_CNT_W    = $clog2(SAMPLE_WIDTH + 1);
  localparam int SQRT_CNT_W   = $clog2(ROOT_W + 1);
  // product register keeps at least one bit above the 64-bit sum for overflow
  localparam int PROD_W       = (2 * SAMPLE_WIDTH > M2_W) ? 2 * SAMPLE_WIDTH : M2_W + 1;
  localparam int REM_W        = ROOT_W + 2;

  typedef struct packed {
    logic                 start;
    logic [DIV_CNT_W-1:0] len;
  } div_ctrl_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PREP,
    S_QDIV,
    S_BABS,
    S_MUL,
    S_ACC,
    S_VSTART,
    S_VDIV,
    S_TSTART,
    S_TDIV,
    S_SQRT,
    S_DONE
  } state_t;

endpackage

/* hdl/running_mean_variance.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// running_mean_variance
// Welford running mean and variance over signed Q15.16 samples, with
// bit-serial divide, multiply and square root.
// ----------------------------------------------------------------------------
// Sequence: mean divide, multiply, variance divide, standard-error divide and
//   square root, plus control; the two variance-side divides and the square root
//   are skipped while the count is one or less, the mean divide and multiply once it is full.
// Throughput: one transaction at a time; the next is accepted the cycle after
//   the result is written to the output register.
// Reset: synchronous, active low; clears count, mean, deviation sum and control.
// ----------------------------------------------------------------------------
module running_mean_variance (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] in_sample,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [31:0]        out_sample_total,
  output logic signed [31:0] out_mean_value,
  output logic [62:0]        out_variance_value,
  output logic [31:0]        out_std_error,
  output logic               out_variance_valid,
  output logic               out_saturated
);
  import rmv_pkg::*;

  localparam int SW = SAMPLE_WIDTH;
  localparam int CW = COUNT_WIDTH;

  state_t state_r, state_nxt;

  logic signed [SW-1:0] x_r;
  logic signed [SW-1:0] mean_r;
  logic signed [SW-1:0] nmean_r;
  logic [SW-1:0]        a_r;
  logic                 neg_r;
  logic [SW-1:0]        mcand_r;
  logic [SW-1:0]        mplier_r;
  logic [PROD_W-1:0]    acc_r;
  logic [MUL_CNT_W-1:0] mcnt_r;
  logic [CW-1:0]        count_r;
  logic [M2_W-1:0]      m2_r;
  logic                 sat_r;
  logic [VAR_W-1:0]     var_r;
  logic                 vvalid_r;
  logic [DIV_W-1:0]     rad_r;
  logic [REM_W-1:0]     rem_r;
  logic [ROOT_W-1:0]    root_r;
  logic [SQRT_CNT_W-1:0] scnt_r;

  logic                 out_valid_r;
  logic [31:0]          out_total_r;
  logic signed [31:0]   out_mean_r;
  logic [62:0]          out_var_r;
  logic [31:0]          out_se_r;
  logic                 out_vvalid_r;
  logic                 out_sat_r;

  logic                 accept;
  logic                 out_free;
  logic                 out_load;
  logic [SW:0]          delta;
  logic [SW:0]          delta_abs;
  logic [SW:0]          diff;
  logic [SW:0]          diff_abs;
  logic [SW-1:0]        q;
  logic [SW-1:0]        nmean;
  logic [M2_W:0]        m2_sum;
  logic                 prod_ovf;
  logic [REM_W+1:0]     rem_sh;
  logic [REM_W+1:0]     trial;
  logic                 root_ge;

  div_ctrl_t            div_ctrl;
  logic [DIV_W-1:0]     div_dividend;
  logic [CW-1:0]        div_divisor;
  logic [DIV_W-1:0]     div_quot;
  logic                 div_done;

  rmv_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (div_ctrl),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quotient (div_quot),
    .done     (div_done)
  );

  // datapath helpers
  always_comb begin
    delta     = {x_r[SW-1], x_r} - {mean_r[SW-1], mean_r};
    delta_abs = delta[SW] ? (~delta + 1'b1) : delta;
    q         = div_quot[SW-1:0];
    nmean     = mean_r + (neg_r ? (~q + 1'b1) : q);
    diff      = {x_r[SW-1], x_r} - {nmean_r[SW-1], nmean_r};
    diff_abs  = diff[SW] ? (~diff + 1'b1) : diff;
    prod_ovf  = |acc_r[PROD_W-1:M2_W];
    m2_sum    = {1'b0, m2_r} + {1'b0, acc_r[M2_W-1:0]};
    rem_sh    = {rem_r, rad_r[DIV_W-1:DIV_W-2]};
    trial     = (REM_W+2)'({root_r, 2'b01});
    root_ge   = (rem_sh >= trial);
  end

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  // next state and divider control
  always_comb begin
    state_nxt    = state_r;
    out_load     = 1'b0;
    div_ctrl     = '{start: 1'b0, len: '0};
    div_dividend = m2_r;
    div_divisor  = count_r - 1'b1;
    unique case (state_r)
      S_IDLE: begin
        if (accept) state_nxt = S_PREP;
      end
      S_PREP: begin
        if (sat_r) begin
          state_nxt = S_VSTART;
        end else begin
          div_ctrl     = '{start: 1'b1, len: DIV_CNT_W'(SW)};
          div_dividend = {delta_abs[SW-1:0], {(DIV_W-SW){1'b0}}};
          div_divisor  = count_r + 1'b1;
          state_nxt    = S_QDIV;
        end
      end
      S_QDIV: begin
        if (div_done) state_nxt = S_BABS;
      end
      S_BABS: state_nxt = S_MUL;
      S_MUL: begin
        if (mcnt_r == MUL_CNT_W'(1)) state_nxt = S_ACC;
      end
      S_ACC: state_nxt = S_VSTART;
      S_VSTART: begin
        if (count_r > CW'(1)) begin
          div_ctrl  = '{start: 1'b1, len: DIV_CNT_W'(DIV_W)};
          state_nxt = S_VDIV;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_VDIV: begin
        if (div_done) state_nxt = S_TSTART;
      end
      S_TSTART: begin
        div_ctrl     = '{start: 1'b1, len: DIV_CNT_W'(DIV_W)};
        div_dividend = DIV_W'(var_r);
        div_divisor  = count_r;
        state_nxt    = S_TDIV;
      end
      S_TDIV: begin
        if (div_done) state_nxt = S_SQRT;
      end
      S_SQRT: begin
        if (scnt_r == SQRT_CNT_W'(1)) state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // accumulated state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      mean_r  <= '0;
      m2_r    <= '0;
    end else if (state_r == S_ACC) begin
      count_r <= count_r + 1'b1;
      mean_r  <= nmean_r;
      if (prod_ovf || m2_sum[M2_W]) begin
        m2_r <= '1;
      end else begin
        m2_r <= m2_sum[M2_W-1:0];
      end
    end
  end

  // per-transaction working registers
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          x_r   <= SW'(in_sample);
          sat_r <= &count_r;
        end
      end
      S_PREP: begin
        a_r   <= delta_abs[SW-1:0];
        neg_r <= delta[SW];
      end
      S_QDIV: begin
        if (div_done) nmean_r <= nmean;
      end
      S_BABS: begin
        mcand_r  <= diff_abs[SW-1:0];
        mplier_r <= a_r;
        acc_r    <= '0;
        mcnt_r   <= MUL_CNT_W'(SW);
      end
      S_MUL: begin
        acc_r    <= {acc_r[PROD_W-2:0], 1'b0} +
                    (mplier_r[SW-1] ? PROD_W'(mcand_r) : PROD_W'(0));
        mplier_r <= {mplier_r[SW-2:0], 1'b0};
        mcnt_r   <= mcnt_r - 1'b1;
      end
      S_ACC: begin
        if (prod_ovf || m2_sum[M2_W]) sat_r <= 1'b1;
      end
      S_VSTART: begin
        vvalid_r <= (count_r > CW'(1));
        var_r    <= '0;
        root_r   <= '0;
      end
      S_VDIV: begin
        if (div_done) var_r <= div_quot[DIV_W-1] ? '1 : div_quot[VAR_W-1:0];
      end
      S_TDIV: begin
        if (div_done) begin
          rad_r  <= div_quot;
          rem_r  <= '0;
          root_r <= '0;
          scnt_r <= SQRT_CNT_W'(ROOT_W);
        end
      end
      S_SQRT: begin
        rad_r  <= {rad_r[DIV_W-3:0], 2'b00};
        scnt_r <= scnt_r - 1'b1;
        if (root_ge) begin
          rem_r  <= REM_W'(rem_sh - trial);
          root_r <= {root_r[ROOT_W-2:0], 1'b1};
        end else begin
          rem_r  <= rem_sh[REM_W-1:0];
          root_r <= {root_r[ROOT_W-2:0], 1'b0};
        end
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_total_r  <= 32'(count_r);
      out_mean_r   <= 32'(mean_r);
      out_var_r    <= var_r;
      out_se_r     <= 32'(root_r);
      out_vvalid_r <= vvalid_r;
      out_sat_r    <= sat_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_sample_total   = out_total_r;
  assign out_mean_value     = out_mean_r;
  assign out_variance_value = out_var_r;
  assign out_std_error      = out_se_r;
  assign out_variance_valid = out_vvalid_r;
  assign out_saturated      = out_sat_r;

`ifndef ASSERT_OFF
  a_div_done_phase: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_QDIV || state_r == S_VDIV || state_r == S_TDIV))
    else $error("divider finished outside a wait state");

  a_valid_total: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_vvalid_r) |-> (out_total_r > 32'd1))
    else $error("variance flagged valid with total below two");

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_vvalid_r) |-> (out_var_r == '0 && out_se_r == '0))
    else $error("undefined variance transaction carries nonzero fields");

  a_load_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> (out_valid_r && state_r == S_IDLE))
    else $error("result load did not present a transaction");
`endif

endmodule

/* hdl/rmv_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmv_div
// Restoring divider, one quotient bit per cycle. The dividend is loaded
// left-aligned; after len steps the quotient sits in the low len bits.
// ----------------------------------------------------------------------------
module rmv_div (
  input  logic                                clk,
  input  logic                                rst_n,
  input  rmv_pkg::div_ctrl_t                  ctrl,
  input  logic [rmv_pkg::DIV_W-1:0]           dividend,
  input  logic [rmv_pkg::COUNT_WIDTH-1:0]     divisor,
  output logic [rmv_pkg::DIV_W-1:0]           quotient,
  output logic                                done
);
  import rmv_pkg::*;

  logic [DIV_W-1:0]       dq_r;
  logic [COUNT_WIDTH-1:0] rem_r;
  logic [COUNT_WIDTH-1:0] dvs_r;
  logic [DIV_CNT_W-1:0]   cnt_r;
  logic                   busy_r;
  logic                   done_r;

  logic [COUNT_WIDTH:0]   rem_sh;
  logic [COUNT_WIDTH:0]   rem_dif;
  logic                   ge;

  always_comb begin
    rem_sh  = {rem_r, dq_r[DIV_W-1]};
    ge      = (rem_sh >= {1'b0, dvs_r});
    rem_dif = rem_sh - {1'b0, dvs_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (ctrl.start) begin
        busy_r <= 1'b1;
        cnt_r  <= ctrl.len;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == DIV_CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      dq_r  <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= ge ? rem_dif[COUNT_WIDTH-1:0] : rem_sh[COUNT_WIDTH-1:0];
      dq_r  <= {dq_r[DIV_W-2:0], ge};
    end
  end

  assign quotient = dq_r;
  assign done     = done_r;

endmodule

/* test/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for running_mean_variance. A queue of Q15.16 samples
// (directed extremes, then small deviations around zero, then full-range
// noise that drives the deviation sum into saturation) feeds a clocked
// driver. A clocked monitor tracks count, mean and deviation sum on every
// accepted input transaction and checks each result transaction field by
// field against the oldest expectation.
// ----------------------------------------------------------------------------
module tb_top;
  import rmv_pkg::*;

  localparam int          DIRECTED_N = 15;
  localparam int          RANDOM_N   = 1650;
  localparam int          NOISE_N    = 40;
  localparam int          PHASE_LEN  = 150;
  localparam int          QUIET_MAX  = 5000;
  localparam logic [63:0] COUNT_FULL = (64'd1 << COUNT_WIDTH) - 64'd1;
  localparam logic [63:0] VAR_MAX    = 64'h7FFF_FFFF_FFFF_FFFF;

  typedef struct {
    logic [31:0]        total;
    logic signed [31:0] mean;
    logic [62:0]        variance;
    logic [31:0]        std_err;
    logic               var_ok;
    logic               sat;
  } stat_result_t;

  logic               clk;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic signed [31:0] in_sample = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [31:0]        out_sample_total;
  logic signed [31:0] out_mean_value;
  logic [62:0]        out_variance_value;
  logic [31:0]        out_std_error;
  logic               out_variance_valid;
  logic               out_saturated;

  logic signed [31:0] sample_q[$];
  stat_result_t       stats_expected_q[$];
  int                 total_items;
  int                 n_sent = 0;
  int                 n_done = 0;
  int                 n_sat = 0;
  int                 errors = 0;
  int                 quiet = 0;

  // tracked accumulator state
  logic [63:0]        acc_count = '0;
  longint             acc_mean = 0;
  logic [63:0]        acc_m2 = '0;

  running_mean_variance u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_sample          (in_sample),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_sample_total   (out_sample_total),
    .out_mean_value     (out_mean_value),
    .out_variance_value (out_variance_value),
    .out_std_error      (out_std_error),
    .out_variance_valid (out_variance_valid),
    .out_saturated      (out_saturated)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // idle odds per phase: none, sender only, receiver only, both lightly
  function automatic int idle_odds(input int done, input bit rx_side);
    case ((done / PHASE_LEN) % 4)
      1: return rx_side ? 0 : 46;
      2: return rx_side ? 46 : 0;
      3: return 6;
      default: return 0;
    endcase
  endfunction

  function automatic stat_result_t welford_update(input logic signed [31:0] sample);
    stat_result_t r;
    longint       x;
    longint       delta;
    longint       nmean;
    longint       diff;
    logic [63:0]  n;
    logic [63:0]  a;
    logic [63:0]  b;
    logic [63:0]  q;
    logic [63:0]  prod;
    logic [63:0]  var_w;
    logic [63:0]  quot;
    logic [63:0]  trial;
    logic [127:0] prod_w;
    logic [64:0]  sum_w;
    logic [31:0]  root;
    logic         sat;
    sat = 1'b0;
    if (acc_count >= COUNT_FULL) begin
      sat = 1'b1;
    end else begin
      x      = longint'(sample);
      n      = acc_count + 64'd1;
      delta  = x - acc_mean;
      a      = (delta < 0) ? -delta : delta;
      q      = a / n;
      nmean  = (delta < 0) ? acc_mean - longint'(q) : acc_mean + longint'(q);
      diff   = x - nmean;
      b      = (diff < 0) ? -diff : diff;
      prod_w = a * b;
      if (prod_w[127:64] != 0) begin
        prod = '1;
        sat  = 1'b1;
      end else begin
        prod = prod_w[63:0];
      end
      sum_w = acc_m2 + prod;
      if (sum_w[64]) begin
        acc_m2 = '1;
        sat    = 1'b1;
      end else begin
        acc_m2 = sum_w[63:0];
      end
      acc_count = n;
      acc_mean  = nmean;
    end
    var_w = '0;
    root  = '0;
    if (acc_count > 64'd1) begin
      var_w = acc_m2 / (acc_count - 64'd1);
      if (var_w > VAR_MAX) var_w = VAR_MAX;
      quot = var_w / acc_count;
      for (int i = 31; i >= 0; i--) begin
        trial = {32'b0, root | (32'd1 << i)};
        if (trial * trial <= quot) root = trial[31:0];
      end
    end
    r.total    = acc_count[31:0];
    r.mean     = acc_mean[31:0];
    r.variance = var_w[62:0];
    r.std_err  = root;
    r.var_ok   = acc_count > 64'd1;
    r.sat      = sat;
    return r;
  endfunction

  task automatic check_field(input string what, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s expected %0h got %0h", $time, what, want, got);
    end
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) n_sent++;
      if (sample_q.size() > 0 && !(n_sent == DIRECTED_N && n_done < n_sent) &&
          $urandom_range(0, 99) >= idle_odds(n_sent, 1'b0)) begin
        in_valid  <= 1'b1;
        in_sample <= sample_q.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor and scoreboard
  always @(posedge clk) begin
    stat_result_t exp_r;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        stats_expected_q.insert(stats_expected_q.size(), welford_update(in_sample));
      end
      if (out_valid && !out_stall) begin
        if (stats_expected_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result transaction, total %0h", $time, out_sample_total);
        end else begin
          exp_r = stats_expected_q.pop_front();
          if (exp_r.sat) n_sat++;
          check_field("sample_total", exp_r.total, out_sample_total);
          check_field("mean_value", exp_r.mean, out_mean_value);
          check_field("variance_value", exp_r.variance, out_variance_value);
          check_field("std_error", exp_r.std_err, out_std_error);
          check_field("variance_valid", exp_r.var_ok, out_variance_valid);
          check_field("saturated", exp_r.sat, out_saturated);
        end
        n_done <= n_done + 1;
      end
      out_stall <= ($urandom_range(0, 99) < idle_odds(n_done, 1'b1));
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_MAX) begin
      $display("%0t: no transaction for %0d cycles", $time, QUIET_MAX);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    int                 k;
    logic signed [31:0] off;
    // first sample leaves variance undefined; min then max restores mean to zero
    sample_q = '{32'sd0, 32'sd0, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sd1, -32'sd1,
                 -32'sd3, 32'sd5, 32'sh0001_0000, -32'sh0001_0000, 32'sh00FF_FFFF,
                 -32'sh0100_0000, 32'sd2, -32'sd2, 32'sd7};
    // small deviations keep the deviation sum clear of its limit
    for (int i = 0; i < RANDOM_N; i++) begin
      k   = $urandom_range(0, 24);
      off = (k == 0) ? 32'sd0 : $urandom_range(0, (1 << k) - 1);
      if ($urandom_range(0, 1)) off = -off;
      sample_q.insert(sample_q.size(), off);
    end
    // full-range noise pushes the deviation sum into saturation
    for (int i = 0; i < NOISE_N; i++) sample_q.insert(sample_q.size(), $urandom);
    total_items = sample_q.size();

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    wait (n_done >= total_items);
    repeat (400) @(posedge clk);
    if (stats_expected_q.size() != 0) begin
      errors++;
      $display("%0t: %0d expected results never arrived", $time, stats_expected_q.size());
    end
    $display("Checked %0d results from %0d samples: directed extremes, small deviations,",
             n_done, total_items);
    $display("full-range noise; %0d results flagged saturated, %0d errors", n_sat, errors);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
